// ----- src/mnpgs_pkg.sv -----
package mnpgs_pkg;

  // fixed port widths and internal sizes
  localparam int OUT_W   = 32;
  localparam int CNT_W   = 23;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;
  localparam int TDATA_W = 56;
  localparam int WT_W    = 6;
  localparam int TAP_W   = 4;
  localparam int NTAPS   = 9;

  typedef enum logic [IDX_W-1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_CYCLIC  = 2'd2,
    REG_MISSING = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    ROW_UP,
    ROW_MID,
    ROW_DN
  } row_sel_e;

  typedef enum logic [1:0] {
    COL_L,
    COL_C,
    COL_R
  } col_sel_e;

  typedef struct packed {
    row_sel_e   row_sel;
    col_sel_e   col_sel;
    logic [3:0] weight;
  } tap_t;

  // stencil taps, centre first
  function automatic tap_t tap_info(logic [TAP_W-1:0] k);
    tap_t t;
    case (k)
      4'd1:    t = '{ROW_UP,  COL_L, 4'd3};
      4'd2:    t = '{ROW_UP,  COL_C, 4'd5};
      4'd3:    t = '{ROW_UP,  COL_R, 4'd3};
      4'd4:    t = '{ROW_MID, COL_L, 4'd5};
      4'd5:    t = '{ROW_MID, COL_R, 4'd5};
      4'd6:    t = '{ROW_DN,  COL_L, 4'd3};
      4'd7:    t = '{ROW_DN,  COL_C, 4'd5};
      4'd8:    t = '{ROW_DN,  COL_R, 4'd3};
      default: t = '{ROW_MID, COL_C, 4'd10};
    endcase
    return t;
  endfunction

endpackage

// ----- src/mnpgs_ram.sv -----
module mnpgs_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/masked_nine_point_grid_smoother.sv -----
// Masked nine-point grid smoother.
// Input stream: one word per cell in raster order. tdata carries the cell value,
// tuser the mode (0 sample, 1 drain). Output stream: tdata {missing_count,
// smoothed_value}, tuser is_missing, tlast marks the last cell of the field.
// Config port: write columns, rows, cyclic, missing_value while idle; writing
// columns or rows restarts the field.
// A sample is written to a four-row line store. Once the cell two rows minus one
// behind the input has its full neighborhood, one result is computed: nine reads
// from the single store read port, then a bit-serial rounding divide, then the
// result is loaded into the output register once it is free. No new word is taken
// while a result is being computed. After the last sample, drain words push out
// the remaining rows of results.
// Reset clears positions, tally and the output register; the line store needs no
// clearing since only cells of the current field are read. If the receiver
// stalls, the finished result waits in the output register and the next word is
// still taken; a further result waits until that register is free.
module masked_nine_point_grid_smoother #(
  parameter int MAX_COLS    = 1024,
  parameter int MAX_ROWS    = 4096,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // cell_value
  input  logic                          s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mnpgs_pkg::TDATA_W-1:0] m_axis_tdata,  // smoothed_value, missing_count
  output logic                          m_axis_tuser,  // is_missing
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [mnpgs_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [mnpgs_pkg::CFG_W-1:0]   cfg_data_i
);
  import mnpgs_pkg::*;

  localparam int VW  = VALUE_WIDTH;
  localparam int SW  = VW + 7;
  localparam int CW  = $clog2(MAX_COLS);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int RW  = ($clog2(MAX_ROWS) > 2) ? $clog2(MAX_ROWS) : 2;
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int PW  = $clog2(2 * MAX_COLS + 1);
  localparam int AW  = CW + 2;
  localparam int DCW = $clog2(SW + 1);

  // config registers
  logic [CNW-1:0] cols_q;
  logic [RNW-1:0] rows_q;
  logic           cyclic_q;
  logic [31:0]    missing_q;
  logic [CNW-1:0] cols_d;
  logic [RNW-1:0] rows_d;
  logic [31:0]    ccol, crow;
  logic           cfg_restart;

  always_comb begin
    ccol = {21'd0, cfg_data_i[10:0]};
    crow = {19'd0, cfg_data_i[12:0]};
    if (ccol == 32'd0)                cols_d = CNW'(1);
    else if (ccol > 32'(MAX_COLS))    cols_d = CNW'(MAX_COLS);
    else                              cols_d = CNW'(ccol);
    if (crow == 32'd0)                rows_d = RNW'(1);
    else if (crow > 32'(MAX_ROWS))    rows_d = RNW'(MAX_ROWS);
    else                              rows_d = RNW'(crow);
    cfg_restart = cfg_we_i && (cfg_idx_i == REG_COLUMNS || cfg_idx_i == REG_ROWS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= CNW'(MAX_COLS < 1024 ? MAX_COLS : 1024);
      rows_q    <= RNW'(MAX_ROWS < 1024 ? MAX_ROWS : 1024);
      cyclic_q  <= 1'b0;
      missing_q <= 32'h8000_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COLUMNS: cols_q    <= cols_d;
        REG_ROWS:    rows_q    <= rows_d;
        REG_CYCLIC:  cyclic_q  <= cfg_data_i[0];
        REG_MISSING: missing_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // missing value and input value at VALUE_WIDTH bits
  logic [VW+31:0] mv_ext, cv_ext;
  logic [VW-1:0]  mv_vw, cv_vw;
  assign mv_ext = {{VW{missing_q[31]}}, missing_q};
  assign mv_vw  = mv_ext[VW-1:0];
  assign cv_ext = {{VW{1'b0}}, s_axis_tdata};
  assign cv_vw  = cv_ext[VW-1:0];

  // state
  state_e          state_q, state_d;
  logic [RW-1:0]   in_row_q, out_row_q;
  logic [CW-1:0]   in_col_q, out_col_q;
  logic            full_q;
  logic [PW-1:0]   pend_q;
  logic [CNT_W-1:0] tally_q;
  logic [TAP_W-1:0] tap_q;
  tap_t            tap_prev_q;
  logic            en_prev_q;
  logic            ctr_valid_q;
  logic signed [SW-1:0] sum_q;
  logic [WT_W-1:0] wsum_q;
  logic            neg_q;
  logic [SW-1:0]   num_q;
  logic [WT_W:0]   rem_q;
  logic [DCW-1:0]  dcnt_q;
  logic            out_valid_q;
  logic [TDATA_W-1:0] out_data_q;
  logic            out_user_q, out_last_q;

  // input step
  logic in_fire, do_write, col_last, row_last, full_w, due;
  logic [PW-1:0] pend_w;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign do_write = in_fire && !s_axis_tuser && !full_q;
  assign col_last = 32'(in_col_q) + 32'd1 >= 32'(cols_q);
  assign row_last = 32'(in_row_q) + 32'd1 >= 32'(rows_q);
  assign full_w   = full_q || (do_write && col_last && row_last);
  assign pend_w   = pend_q + PW'(do_write);
  assign due      = full_w || (32'(pend_w) >= 32'd2 * 32'(cols_q));

  // neighborhood geometry of the output cell
  logic has_up, has_dn, has_l, has_r, oc_last, or_last, last_cell, out_free;
  logic [CW-1:0] lcol, rcol;
  assign oc_last   = 32'(out_col_q) + 32'd1 >= 32'(cols_q);
  assign or_last   = 32'(out_row_q) + 32'd1 >= 32'(rows_q);
  assign last_cell = oc_last && or_last;
  assign has_up    = out_row_q != '0;
  assign has_dn    = !or_last;
  assign has_l     = out_col_q != '0 || cyclic_q;
  assign has_r     = !oc_last || cyclic_q;
  assign lcol      = (out_col_q != '0) ? out_col_q - CW'(1) : CW'(cols_q - CNW'(1));
  assign rcol      = oc_last ? '0 : out_col_q + CW'(1);
  assign out_free  = !out_valid_q || m_axis_tready;

  // tap address and enable
  tap_t          tap_cur;
  logic [1:0]    tap_row;
  logic [CW-1:0] tap_col;
  logic          tap_en;
  always_comb begin
    tap_cur = tap_info(tap_q);
    tap_en  = 1'b1;
    case (tap_cur.row_sel)
      ROW_UP:  begin tap_row = out_row_q[1:0] - 2'd1; tap_en = has_up; end
      ROW_DN:  begin tap_row = out_row_q[1:0] + 2'd1; tap_en = has_dn; end
      default: tap_row = out_row_q[1:0];
    endcase
    case (tap_cur.col_sel)
      COL_L:   begin tap_col = lcol; tap_en = tap_en && has_l; end
      COL_R:   begin tap_col = rcol; tap_en = tap_en && has_r; end
      default: tap_col = out_col_q;
    endcase
  end

  // line store
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW:0]   ram_wdata, ram_rdata;
  assign ram_waddr = {in_row_q[1:0], in_col_q};
  assign ram_wdata = {cv_vw != mv_vw, cv_vw};
  assign ram_raddr = {tap_row, tap_col};

  mnpgs_ram #(
    .WIDTH(VW + 1),
    .DEPTH(4 * (2 ** CW))
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // weighted term of the returning tap
  logic signed [SW-1:0] rd_ext, term;
  logic                 term_en;
  assign rd_ext  = SW'($signed(ram_rdata[VW-1:0]));
  assign term    = rd_ext * $signed({1'b0, tap_prev_q.weight});
  assign term_en = en_prev_q && ram_rdata[VW];

  // divider step
  logic [WT_W:0]   rem_sh;
  logic            qbit;
  logic [SW-1:0]   mag;
  assign rem_sh = {rem_q[WT_W-1:0], num_q[SW-1]};
  assign qbit   = rem_sh >= {1'b0, wsum_q};
  assign mag    = (sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q)) + SW'(wsum_q >> 1);

  // result
  logic [SW-1:0]      qres;
  logic [VW-1:0]      res_vw;
  logic [VW+31:0]     res_ext;
  logic [CNT_W-1:0]   tally_new;
  assign qres      = neg_q ? SW'(-num_q) : num_q;
  assign res_vw    = ctr_valid_q ? qres[VW-1:0] : mv_vw;
  assign res_ext   = {32'd0, res_vw};
  assign tally_new = ctr_valid_q ? tally_q : tally_q + CNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire && due) state_d = S_READ;
      S_READ: if (tap_q == TAP_W'(NTAPS)) state_d = S_DIV;
      S_DIV:  if (dcnt_q == DCW'(SW)) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = state_q == S_IDLE;
    ram_we        = do_write;
  end

  // positions and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      full_q    <= 1'b0;
      pend_q    <= '0;
      tally_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_restart) begin
        in_row_q  <= '0;
        in_col_q  <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
        full_q    <= 1'b0;
        pend_q    <= '0;
        tally_q   <= '0;
      end else if (state_q == S_IDLE && in_fire) begin
        full_q <= full_w;
        pend_q <= pend_w;
        if (do_write) begin
          if (col_last) begin
            in_col_q <= '0;
            if (!row_last) in_row_q <= in_row_q + RW'(1);
          end else begin
            in_col_q <= in_col_q + CW'(1);
          end
        end
      end else if (state_q == S_DONE && out_free) begin
        if (last_cell) begin
          in_row_q  <= '0;
          in_col_q  <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
          full_q    <= 1'b0;
          pend_q    <= '0;
          tally_q   <= '0;
        end else begin
          tally_q <= tally_new;
          pend_q  <= pend_q - PW'(1);
          if (oc_last) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + RW'(1);
          end else begin
            out_col_q <= out_col_q + CW'(1);
          end
        end
      end
    end
  end

  // tap sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (state_q == S_READ) tap_q <= tap_q + TAP_W'(1);
      else                   tap_q <= '0;
      if (state_q == S_DIV)  dcnt_q <= dcnt_q + DCW'(1);
      else                   dcnt_q <= '0;
    end
  end

  // accumulate and divide
  always_ff @(posedge clk_i) begin
    tap_prev_q <= tap_cur;
    en_prev_q  <= tap_en;
    if (state_q == S_IDLE) begin
      sum_q  <= '0;
      wsum_q <= '0;
    end else if (state_q == S_READ && tap_q != '0) begin
      if (tap_q == TAP_W'(1)) ctr_valid_q <= ram_rdata[VW];
      if (term_en) begin
        sum_q  <= sum_q + term;
        wsum_q <= wsum_q + WT_W'(tap_prev_q.weight);
      end
    end
    if (state_q == S_DIV) begin
      if (dcnt_q == '0) begin
        neg_q <= sum_q[SW-1];
        num_q <= mag;
        rem_q <= '0;
      end else begin
        rem_q <= qbit ? rem_sh - {1'b0, wsum_q} : rem_sh;
        num_q <= {num_q[SW-2:0], qbit};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_data_q <= {1'b0, tally_new, res_ext[OUT_W-1:0]};
      out_user_q <= !ctr_valid_q;
      out_last_q <= last_cell;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_IDLE)
    else $error("line store written outside idle");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= 32'd2 * 32'(cols_q))
    else $error("pending cell count beyond two rows");

  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> tap_q <= TAP_W'(NTAPS))
    else $error("tap counter overrun");

  a_done_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded");

endmodule

// ----- sim/masked_nine_point_grid_smoother_tb.sv -----
`timescale 1ns / 1ps

module masked_nine_point_grid_smoother_tb;
  import mnpgs_pkg::*;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 4096;
  localparam int LAT      = 80;

  // mode codes of an input word
  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef struct {
    logic [31:0] value;
    logic        miss;
    logic        last;
    logic [22:0] count;
  } smooth_res_t;

  typedef struct {
    logic        mode;
    logic [31:0] value;
  } cell_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // cell_value
  logic s_axis_tuser = 1'b0;        // mode
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata; // smoothed_value, missing_count
  logic m_axis_tuser;               // is_missing
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = REG_COLUMNS;
  logic [CFG_W-1:0] cfg_data_i = '0;

  masked_nine_point_grid_smoother DUT (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] grid_val [4*MAX_COLS];
  logic               grid_ok  [4*MAX_COLS];
  int unsigned n_cols, n_rows, wrap;
  logic [31:0] miss_word;
  int unsigned in_r, in_c, out_r, out_c, tally;
  bit full;

  smooth_res_t want_q[$];
  int errors = 0;
  bit hold_off = 1'b0;

  task automatic restart_grid();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0; tally = 0; full = 0;
  endtask

  function automatic void tap(int unsigned r, int unsigned c, longint w,
                              ref longint sum, ref longint wsum);
    int unsigned k;
    k = (r % 4) * MAX_COLS + c;
    if (grid_ok[k]) begin
      sum += w * longint'(grid_val[k]);
      wsum += w;
    end
  endfunction

  // next smoothed cell, if this word releases one
  task automatic smooth_step(cell_word_t wd);
    longint cnt, m, sum, wsum, q;
    int unsigned r, c, lc, rc, k;
    bit up, dn, hl, hr, last;
    smooth_res_t res;
    if (wd.mode == MODE_CELL && !full) begin
      k = (in_r % 4) * MAX_COLS + in_c;
      grid_val[k] = wd.value;
      grid_ok[k] = (wd.value != miss_word);
      if (in_c + 1 >= n_cols) begin
        in_c = 0;
        if (in_r + 1 >= n_rows) full = 1; else in_r++;
      end else in_c++;
    end
    cnt = full ? longint'(n_rows) * n_cols : longint'(in_r) * n_cols + in_c;
    m = longint'(out_r) * n_cols + out_c;
    if (!full && cnt < m + 2 * longint'(n_cols)) return;
    r = out_r; c = out_c;
    up = r != 0; dn = r + 1 < n_rows;
    hl = (c != 0) || wrap; hr = (c + 1 < n_cols) || wrap;
    lc = c != 0 ? c - 1 : n_cols - 1;
    rc = c + 1 < n_cols ? c + 1 : 0;
    last = (r + 1 >= n_rows) && (c + 1 >= n_cols);
    k = (r % 4) * MAX_COLS + c;
    if (grid_ok[k]) begin
      sum = 10 * longint'(grid_val[k]); wsum = 10;
      if (up) begin
        if (hl) tap(r - 1, lc, 3, sum, wsum);
        tap(r - 1, c, 5, sum, wsum);
        if (hr) tap(r - 1, rc, 3, sum, wsum);
      end
      if (hl) tap(r, lc, 5, sum, wsum);
      if (hr) tap(r, rc, 5, sum, wsum);
      if (dn) begin
        if (hl) tap(r + 1, lc, 3, sum, wsum);
        tap(r + 1, c, 5, sum, wsum);
        if (hr) tap(r + 1, rc, 3, sum, wsum);
      end
      if (sum >= 0) q = (sum + wsum / 2) / wsum;
      else q = -((-sum + wsum / 2) / wsum);
      res.value = q[31:0]; res.miss = 0;
    end else begin
      res.value = miss_word; res.miss = 1;
      tally = (tally + 1) & 23'h7FFFFF;
    end
    res.last = last; res.count = tally[22:0];
    want_q.push_back(res);
    if (last) restart_grid();
    else if (c + 1 >= n_cols) begin out_c = 0; out_r++; end
    else out_c++;
  endtask

  // register write, mirrored into the predictor
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    int unsigned v;
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_COLUMNS: begin
        v = val & 32'h7FF;
        n_cols = v == 0 ? 1 : (v > MAX_COLS ? MAX_COLS : v);
        restart_grid();
      end
      REG_ROWS: begin
        v = val & 32'h1FFF;
        n_rows = v == 0 ? 1 : (v > MAX_ROWS ? MAX_ROWS : v);
        restart_grid();
      end
      REG_CYCLIC: wrap = val[0];
      REG_MISSING: miss_word = val;
      default: ;
    endcase
  endtask

  // send one word in a burst-and-gap pattern
  int burst_left = 0;
  task automatic send_word(cell_word_t wd);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) * ($urandom_range(0, 2) == 0);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1; s_axis_tuser <= wd.mode; s_axis_tdata <= wd.value;
    do @(posedge clk_i); while (!s_axis_tready);
    smooth_step(wd);
  endtask

  task automatic idle_wait();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_cell();
    case ($urandom_range(0, 5))
      0: return miss_word;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      3: return $urandom;
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  // one whole field plus drain words until it is out
  task automatic run_field(int n_extra_drain);
    cell_word_t wd;
    int n;
    n = n_cols * n_rows;
    for (int i = 0; i < n; i++) begin
      wd.mode = ($urandom_range(0, 30) == 0) ? MODE_DRAIN : MODE_CELL;
      wd.value = rand_cell();
      send_word(wd);
      if (wd.mode == MODE_DRAIN) i--;
    end
    while (full) begin
      wd.mode = $urandom_range(0, 4) == 0 ? MODE_CELL : MODE_DRAIN;
      wd.value = $urandom;
      send_word(wd);
    end
    for (int i = 0; i < n_extra_drain; i++) begin
      wd.mode = MODE_DRAIN; wd.value = $urandom;
      send_word(wd);
    end
  endtask

  // directed words on a 3x3 grid: extremes, missing cells, drains
  cell_word_t dir_tab [] = '{
    '{MODE_DRAIN, 32'h0},
    '{MODE_CELL, 32'h7FFFFFFF}, '{MODE_CELL, 32'h80000000}, '{MODE_CELL, 32'h0},
    '{MODE_CELL, 32'hFFFFFFFF}, '{MODE_CELL, 32'h80000001}, '{MODE_CELL, 32'h7FFFFFFF},
    '{MODE_CELL, 32'h7FFFFFFF}, '{MODE_CELL, 32'h12345678}, '{MODE_CELL, 32'h7FFFFFFF},
    '{MODE_CELL, 32'hDEADBEEF}, '{MODE_DRAIN, 32'h0}, '{MODE_DRAIN, 32'h0},
    '{MODE_DRAIN, 32'h0}, '{MODE_DRAIN, 32'h0}, '{MODE_DRAIN, 32'h0}
  };

  // stimulus
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    n_cols = 1024; n_rows = 1024; wrap = 0; miss_word = 32'h80000000;
    restart_grid();
    @(posedge clk_i);
    write_reg(REG_COLUMNS, 3);
    write_reg(REG_ROWS, 3);
    foreach (dir_tab[i]) send_word(dir_tab[i]);
    idle_wait();
    // one column with wrap: left and right neighbours are the cell itself
    write_reg(REG_CYCLIC, 1);
    write_reg(REG_MISSING, 32'h7FFFFFFF);
    write_reg(REG_COLUMNS, 0);
    write_reg(REG_ROWS, 4);
    run_field(1);
    idle_wait();
    // one row, full mask bits
    write_reg(REG_MISSING, 32'hFFFFFFFF);
    write_reg(REG_COLUMNS, 7);
    write_reg(REG_ROWS, 0);
    run_field(0);
    idle_wait();
    // long stall while the sender keeps going
    write_reg(REG_CYCLIC, 0);
    write_reg(REG_COLUMNS, 2);
    write_reg(REG_ROWS, 3);
    hold_off = 1'b1;
    run_field(2);
    idle_wait();
    // abandoned field: geometry write mid-field
    write_reg(REG_COLUMNS, 5);
    write_reg(REG_ROWS, 5);
    for (int i = 0; i < 7; i++) send_word('{MODE_CELL, rand_cell()});
    idle_wait();
    // one wide two-row field, the largest sizes are too slow
    write_reg(REG_COLUMNS, 240);
    write_reg(REG_ROWS, 2);
    write_reg(REG_MISSING, 32'h80000000);
    run_field(0);
    idle_wait();
    write_reg(REG_ROWS, 13'h1FFF);
    write_reg(REG_COLUMNS, 1);
    write_reg(REG_ROWS, 5);
    run_field(0);
    idle_wait();
    // random small grids
    for (int f = 0; f < 12; f++) begin
      write_reg(REG_CYCLIC, $urandom_range(0, 1));
      write_reg(REG_MISSING, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 20) - 10);
      write_reg(REG_COLUMNS, $urandom_range(1, 6));
      write_reg(REG_ROWS, $urandom_range(1, 6));
      run_field($urandom_range(0, 2));
      idle_wait();
    end
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: stall pattern, plus one long hold-off
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 255) < 160) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    smooth_res_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (want_q.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (m_axis_tdata[31:0] !== w.value) begin
          $error("smoothed_value expected %h got %h", w.value, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tuser !== w.miss) begin
          $error("is_missing expected %b got %b", w.miss, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("field_last expected %b got %b", w.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[54:32] !== w.count) begin
          $error("missing_count expected %0d got %0d", w.count, m_axis_tdata[54:32]);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
